>>> src/cpu_alu_with_flags_assert.svh
// Assertion macros used by the ALU top module
`ifndef CPU_ALU_WITH_FLAGS_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define CALU_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ALU assertion failed");

// Next-cycle implication, disabled in reset
`define CALU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ALU assertion failed");

`endif

>>> src/calu_pkg.sv
package calu_pkg;

   // Operation codes
   localparam logic [4:0] FUNC_ADD   = 5'd0;
   localparam logic [4:0] FUNC_ADC   = 5'd1;
   localparam logic [4:0] FUNC_SUB   = 5'd2;
   localparam logic [4:0] FUNC_CP    = 5'd3;
   localparam logic [4:0] FUNC_AND   = 5'd4;
   localparam logic [4:0] FUNC_OR    = 5'd5;
   localparam logic [4:0] FUNC_XOR   = 5'd6;
   localparam logic [4:0] FUNC_INC   = 5'd7;
   localparam logic [4:0] FUNC_DEC   = 5'd8;
   localparam logic [4:0] FUNC_RLC   = 5'd9;
   localparam logic [4:0] FUNC_RRC   = 5'd10;
   localparam logic [4:0] FUNC_RL    = 5'd11;
   localparam logic [4:0] FUNC_RR    = 5'd12;
   localparam logic [4:0] FUNC_SLA   = 5'd13;
   localparam logic [4:0] FUNC_SRA   = 5'd14;
   localparam logic [4:0] FUNC_SRL   = 5'd15;
   localparam logic [4:0] FUNC_SWAP  = 5'd16;
   localparam logic [4:0] FUNC_BIT   = 5'd17;
   localparam logic [4:0] FUNC_RES   = 5'd18;
   localparam logic [4:0] FUNC_SET   = 5'd19;
   localparam logic [4:0] FUNC_ADD16 = 5'd20;

   // Flag bit positions
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   typedef struct packed {
      logic [4:0]  func;
      logic [15:0] first_operand;
      logic [15:0] second_operand;
      logic [2:0]  bit_index;
      logic [3:0]  flags_in;
   } calu_req_type;

   typedef struct packed {
      logic [15:0] result_value;
      logic [3:0]  flags_out;
   } calu_rsp_type;

endpackage

>>> src/cpu_alu_with_flags.sv
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+-------------------------------
// request   | start, busy, req_item          | transfer when start && !busy
// response  | rsp_strobe, rsp_item           | one-cycle strobe, no back-pressure
//
// Each transfer passes through the request register, then through the
// ALU into the response register.
// A new request is taken every cycle; busy is always low.
// Synchronous active-high reset clears the valid flags only.
// The response side cannot stall, so nothing is ever held back.
module cpu_alu_with_flags
   import calu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  calu_req_type req_item,
   output logic         rsp_strobe,
   output calu_rsp_type rsp_item
);

`include "cpu_alu_with_flags_assert.svh"

   logic         req_valid_ff;
   logic         req_valid_in;
   calu_req_type req_ff;
   calu_req_type req_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   calu_rsp_type rsp_ff;
   calu_rsp_type rsp_in;

   // never stall the requester
   assign busy = 1'b0;

   // capture a request on each transfer
   assign req_valid_in = start && !busy;
   assign req_in       = req_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
   end

   // compute the result
   calu_exec u_exec (
      .req (req_ff),
      .rsp (rsp_in)
   );

   // register the response
   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   `CALU_ASSERT_IMPLY(a_latency, clock, reset, start && !busy, ##2 rsp_strobe)
   `CALU_ASSERT_NEXT(a_no_spurious, clock, reset, !req_valid_ff, !rsp_strobe)
   `CALU_ASSERT_NEXT(a_byte_upper_zero, clock, reset,
      req_valid_ff && req_ff.func != FUNC_ADD16,
      rsp_item.result_value[15:8] == 8'd0)
   `CALU_ASSERT_NEXT(a_bitop_keeps_flags, clock, reset,
      req_valid_ff && (req_ff.func == FUNC_RES || req_ff.func == FUNC_SET),
      rsp_item.flags_out == $past(req_ff.flags_in))

endmodule

>>> src/calu_exec.sv
module calu_exec
   import calu_pkg::*;
(
   input  calu_req_type req,
   output calu_rsp_type rsp
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic        cin;
   logic        add_cin;
   logic [8:0]  sum9;
   logic [4:0]  sum_lo;
   logic [8:0]  diff9;
   logic [4:0]  diff_lo;
   logic [7:0]  inc8;
   logic [7:0]  dec8;
   logic [7:0]  bit_mask;
   logic [16:0] sum17;
   logic [12:0] sum13;
   logic [7:0]  r8;
   logic [3:0]  f;

   // shared adders and subtractors
   always_comb begin
      a       = req.first_operand[7:0];
      b       = req.second_operand[7:0];
      cin     = req.flags_in[FLAG_C];
      add_cin = (req.func == FUNC_ADC) ? cin : 1'b0;
      sum9    = {1'b0, a} + {1'b0, b} + {8'd0, add_cin};
      sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_cin};
      diff9   = {1'b0, a} - {1'b0, b};
      diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]};
      inc8    = a + 8'd1;
      dec8    = a - 8'd1;
      bit_mask = 8'd1 << req.bit_index;
      sum17   = {1'b0, req.first_operand} + {1'b0, req.second_operand};
      sum13   = {1'b0, req.first_operand[11:0]} + {1'b0, req.second_operand[11:0]};
   end

   // select the byte result and flags per operation
   always_comb begin
      r8 = a;
      f  = req.flags_in;
      rsp.result_value = '0;
      case (req.func)
         FUNC_ADD, FUNC_ADC: begin
            r8 = sum9[7:0];
            f  = {r8 == 8'd0, 1'b0, sum_lo[4], sum9[8]};
         end
         FUNC_SUB: begin
            r8 = diff9[7:0];
            f  = {r8 == 8'd0, 1'b1, diff_lo[4], diff9[8]};
         end
         FUNC_CP: begin
            f  = {diff9[7:0] == 8'd0, 1'b1, diff_lo[4], diff9[8]};
         end
         FUNC_AND: begin
            r8 = a & b;
            f  = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
         end
         FUNC_OR: begin
            r8 = a | b;
            f  = {r8 == 8'd0, 3'b000};
         end
         FUNC_XOR: begin
            r8 = a ^ b;
            f  = {r8 == 8'd0, 3'b000};
         end
         FUNC_INC: begin
            r8 = inc8;
            f  = {r8 == 8'd0, 1'b0, a[3:0] == 4'hf, cin};
         end
         FUNC_DEC: begin
            r8 = dec8;
            f  = {r8 == 8'd0, 1'b1, a[3:0] == 4'h0, cin};
         end
         FUNC_RLC: begin
            r8 = {a[6:0], a[7]};
            f  = {r8 == 8'd0, 2'b00, a[7]};
         end
         FUNC_RL: begin
            r8 = {a[6:0], cin};
            f  = {r8 == 8'd0, 2'b00, a[7]};
         end
         FUNC_SLA: begin
            r8 = {a[6:0], 1'b0};
            f  = {r8 == 8'd0, 2'b00, a[7]};
         end
         FUNC_RRC: begin
            r8 = {a[0], a[7:1]};
            f  = {r8 == 8'd0, 2'b00, a[0]};
         end
         FUNC_RR: begin
            r8 = {cin, a[7:1]};
            f  = {r8 == 8'd0, 2'b00, a[0]};
         end
         FUNC_SRA: begin
            r8 = {a[7], a[7:1]};
            f  = {r8 == 8'd0, 2'b00, a[0]};
         end
         FUNC_SRL: begin
            r8 = {1'b0, a[7:1]};
            f  = {r8 == 8'd0, 2'b00, a[0]};
         end
         FUNC_SWAP: begin
            r8 = {a[3:0], a[7:4]};
            f  = {r8 == 8'd0, 3'b000};
         end
         FUNC_BIT: begin
            f  = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
         end
         FUNC_RES: begin
            r8 = a & ~bit_mask;
         end
         FUNC_SET: begin
            r8 = a | bit_mask;
         end
         FUNC_ADD16: begin
            f  = {req.flags_in[FLAG_Z], 1'b0, sum13[12], sum17[16]};
         end
         default: begin
            r8 = a;
            f  = req.flags_in;
         end
      endcase
      // the 16-bit add drives the whole word, everything else a byte
      if (req.func == FUNC_ADD16) begin
         rsp.result_value = sum17[15:0];
      end else begin
         rsp.result_value = {8'd0, r8};
      end
      rsp.flags_out = f;
   end

endmodule

>>> sim/cpu_alu_with_flags_tb.sv
`timescale 1ns / 100ps

module cpu_alu_with_flags_tb
   import calu_pkg::*;
();

   // Hold the expected ALU results in arrival order and check each response
   class alu_scoreboard;
      calu_rsp_type expected_results[$];
      int           error_count;

      // Compute the new value and flags for one operation
      function calu_rsp_type predict_alu_result(calu_req_type rq);
         logic [7:0]   a;
         logic [7:0]   b;
         logic         cin;
         logic         carry_add;
         logic [8:0]   sum9;
         logic [4:0]   nib5;
         logic [16:0]  sum17;
         logic [12:0]  sum13;
         logic [7:0]   r;
         logic [3:0]   f;
         calu_rsp_type rsp;
         a = rq.first_operand[7:0];
         b = rq.second_operand[7:0];
         cin = rq.flags_in[FLAG_C];
         r = a;
         f = rq.flags_in;
         rsp.result_value = 16'h0000;
         case (rq.func)
            FUNC_ADD, FUNC_ADC: begin
               carry_add = (rq.func == FUNC_ADC) ? cin : 1'b0;
               sum9 = {1'b0, a} + {1'b0, b} + {8'h00, carry_add};
               nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, carry_add};
               r = sum9[7:0];
               f = 4'h0;
               f[FLAG_H] = nib5[4];
               f[FLAG_C] = sum9[8];
            end
            FUNC_SUB, FUNC_CP: begin
               sum9 = {1'b0, a} - {1'b0, b};
               r = (rq.func == FUNC_SUB) ? sum9[7:0] : a;
               f = 4'h0;
               f[FLAG_Z] = (sum9[7:0] == 8'h00);
               f[FLAG_N] = 1'b1;
               f[FLAG_H] = (a[3:0] < b[3:0]);
               f[FLAG_C] = (a < b);
            end
            FUNC_AND: begin
               r = a & b;
               f = 4'h0;
               f[FLAG_H] = 1'b1;
            end
            FUNC_OR: begin
               r = a | b;
               f = 4'h0;
            end
            FUNC_XOR, FUNC_SWAP: begin
               r = (rq.func == FUNC_XOR) ? (a ^ b) : {a[3:0], a[7:4]};
               f = 4'h0;
            end
            FUNC_INC: begin
               r = a + 8'h01;
               f = 4'h0;
               f[FLAG_H] = (a[3:0] == 4'hF);
               f[FLAG_C] = cin;
            end
            FUNC_DEC: begin
               r = a - 8'h01;
               f = 4'h0;
               f[FLAG_N] = 1'b1;
               f[FLAG_H] = (a[3:0] == 4'h0);
               f[FLAG_C] = cin;
            end
            FUNC_RLC, FUNC_RL, FUNC_SLA: begin
               if (rq.func == FUNC_RLC) begin
                  r = {a[6:0], a[7]};
               end else if (rq.func == FUNC_RL) begin
                  r = {a[6:0], cin};
               end else begin
                  r = {a[6:0], 1'b0};
               end
               f = 4'h0;
               f[FLAG_C] = a[7];
            end
            FUNC_RRC, FUNC_RR, FUNC_SRA, FUNC_SRL: begin
               if (rq.func == FUNC_RRC) begin
                  r = {a[0], a[7:1]};
               end else if (rq.func == FUNC_RR) begin
                  r = {cin, a[7:1]};
               end else if (rq.func == FUNC_SRA) begin
                  r = {a[7], a[7:1]};
               end else begin
                  r = {1'b0, a[7:1]};
               end
               f = 4'h0;
               f[FLAG_C] = a[0];
            end
            FUNC_BIT: begin
               f = 4'h0;
               f[FLAG_Z] = ~a[rq.bit_index];
               f[FLAG_H] = 1'b1;
               f[FLAG_C] = cin;
            end
            FUNC_RES: begin
               r[rq.bit_index] = 1'b0;
            end
            FUNC_SET: begin
               r[rq.bit_index] = 1'b1;
            end
            default: begin
               // unused codes pass the operand and flags through
            end
         endcase
         // Zero flag follows the byte result for the ops listed here; CP and BIT set it above
         case (rq.func)
            FUNC_ADD, FUNC_ADC, FUNC_SUB, FUNC_AND, FUNC_OR, FUNC_XOR, FUNC_INC,
            FUNC_DEC, FUNC_RLC, FUNC_RRC, FUNC_RL, FUNC_RR, FUNC_SLA, FUNC_SRA,
            FUNC_SRL, FUNC_SWAP: begin
               f[FLAG_Z] = (r == 8'h00);
            end
            default: begin
            end
         endcase
         rsp.result_value = {8'h00, r};
         rsp.flags_out = f;
         // The 16-bit add keeps zero and works on the whole operands
         if (rq.func == FUNC_ADD16) begin
            sum17 = {1'b0, rq.first_operand} + {1'b0, rq.second_operand};
            sum13 = {1'b0, rq.first_operand[11:0]} + {1'b0, rq.second_operand[11:0]};
            rsp.result_value = sum17[15:0];
            rsp.flags_out = 4'h0;
            rsp.flags_out[FLAG_Z] = rq.flags_in[FLAG_Z];
            rsp.flags_out[FLAG_H] = sum13[12];
            rsp.flags_out[FLAG_C] = sum17[16];
         end
         return rsp;
      endfunction

      function void note_request(calu_req_type rq);
         expected_results.push_back(predict_alu_result(rq));
      endfunction

      function void check_result(calu_rsp_type got);
         calu_rsp_type want;
         if (expected_results.size() == 0) begin
            $error("unexpected response: result_value %h flags_out %h",
                   got.result_value, got.flags_out);
            error_count++;
            return;
         end
         want = expected_results.pop_front();
         if (got.result_value !== want.result_value) begin
            $error("result_value: expected %h, actual %h",
                   want.result_value, got.result_value);
            error_count++;
         end
         if (got.flags_out !== want.flags_out) begin
            $error("flags_out: expected %h, actual %h", want.flags_out, got.flags_out);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   calu_req_type req_item;
   logic         rsp_strobe;
   calu_rsp_type rsp_item;

   alu_scoreboard sb = new();

   cpu_alu_with_flags i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Record each accepted transfer and check each response at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_request(req_item);
         end
         if (rsp_strobe) begin
            sb.check_result(rsp_item);
         end
      end
   end

   function automatic calu_req_type make_request(logic [4:0] func, logic [15:0] a,
                                                 logic [15:0] b, logic [2:0] bi,
                                                 logic [3:0] fl);
      calu_req_type rq;
      rq.func = func;
      rq.first_operand = a;
      rq.second_operand = b;
      rq.bit_index = bi;
      rq.flags_in = fl;
      return rq;
   endfunction

   // Bias operands towards nibble and byte boundaries
   function automatic logic [15:0] pick_operand();
      logic [15:0] v;
      case ($urandom_range(9))
         0: v = 16'h0000;
         1: v = 16'hFFFF;
         2: v = {8'($urandom_range(255)), 8'h0F};
         3: v = {8'($urandom_range(255)), 8'h80};
         4: v = {8'($urandom_range(255)), 8'hFF};
         5: v = {4'h0, 12'hFFF};
         default: v = 16'($urandom_range(16'hFFFF));
      endcase
      return v;
   endfunction

   function automatic calu_req_type random_request();
      logic [4:0] func;
      if ($urandom_range(99) < 6) begin
         func = 5'($urandom_range(31, 21));
      end else begin
         func = 5'($urandom_range(FUNC_ADD16));
      end
      return make_request(func, pick_operand(), pick_operand(),
                          3'($urandom_range(7)), 4'($urandom_range(15)));
   endfunction

   // Idle a random number of cycles, then hold the request until it transfers
   task automatic send_request(input calu_req_type rq, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_item <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start and wait for every outstanding response
   task automatic drain_responses();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin
      int idle_pcts [3];
      idle_pcts = '{0, 72, 30};
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: boundary cases of every operation and of unused codes
      send_request(make_request(FUNC_ADD,   16'hAAFF, 16'h5501, 3'd0, 4'h0), 0);
      send_request(make_request(FUNC_ADD,   16'h0000, 16'h0000, 3'd0, 4'hF), 0);
      send_request(make_request(FUNC_ADC,   16'h000F, 16'hFF00, 3'd0, 4'h1), 0);
      send_request(make_request(FUNC_ADC,   16'h00FF, 16'h00FF, 3'd7, 4'h1), 0);
      send_request(make_request(FUNC_SUB,   16'h0000, 16'h0001, 3'd0, 4'h0), 0);
      send_request(make_request(FUNC_SUB,   16'hFF10, 16'h0001, 3'd0, 4'hF), 0);
      send_request(make_request(FUNC_CP,    16'h1242, 16'hFF42, 3'd0, 4'h0), 0);
      send_request(make_request(FUNC_AND,   16'hFFF0, 16'hFF0F, 3'd0, 4'hF), 0);
      send_request(make_request(FUNC_OR,    16'hFF00, 16'hFF00, 3'd0, 4'hF), 0);
      send_request(make_request(FUNC_XOR,   16'h00FF, 16'hFFFF, 3'd0, 4'hF), 0);
      send_request(make_request(FUNC_INC,   16'h00FF, 16'h0000, 3'd0, 4'h1), 0);
      send_request(make_request(FUNC_DEC,   16'hFF00, 16'h0000, 3'd0, 4'h0), 0);
      send_request(make_request(FUNC_RLC,   16'h0080, 16'h0000, 3'd0, 4'h0), 0);
      send_request(make_request(FUNC_RRC,   16'h0001, 16'h0000, 3'd0, 4'h0), 0);
      send_request(make_request(FUNC_RL,    16'h0080, 16'h0000, 3'd0, 4'h1), 0);
      send_request(make_request(FUNC_RR,    16'h0001, 16'h0000, 3'd0, 4'h1), 0);
      send_request(make_request(FUNC_SLA,   16'h0080, 16'h0000, 3'd0, 4'hF), 0);
      send_request(make_request(FUNC_SRA,   16'h0081, 16'h0000, 3'd0, 4'h0), 0);
      send_request(make_request(FUNC_SRL,   16'h0001, 16'h0000, 3'd0, 4'hE), 0);
      send_request(make_request(FUNC_SWAP,  16'hFFA5, 16'h0000, 3'd0, 4'hF), 0);
      send_request(make_request(FUNC_BIT,   16'h007F, 16'h0000, 3'd7, 4'h1), 0);
      send_request(make_request(FUNC_RES,   16'hFFFF, 16'hFFFF, 3'd0, 4'hA), 0);
      send_request(make_request(FUNC_SET,   16'h0000, 16'h0000, 3'd7, 4'h5), 0);
      send_request(make_request(FUNC_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'h8), 0);
      send_request(make_request(FUNC_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'h7), 0);
      send_request(make_request(5'd21,      16'hFF34, 16'h1111, 3'd3, 4'h9), 0);
      send_request(make_request(5'd31,      16'h12CD, 16'hFFFF, 3'd7, 4'hF), 0);
      drain_responses();

      // Random phases with different sender idle rates, fully drained in between
      foreach (idle_pcts[p]) begin
         for (int n = 0; n < 617; n++) begin
            send_request(random_request(), idle_pcts[p]);
         end
         drain_responses();
      end

      repeat (4) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
